/* rtl/core/assert_macros.svh */
// Assertion helpers; clk and arst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSLF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tslf assertion failed");
`define TSLF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tslf assertion failed");
`else
`define TSLF_ASSERT_IMP(lbl, ante, cons)
`define TSLF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/tslf_pkg.sv */
package tslf_pkg;

	typedef enum logic [2:0] {
		REG_BASE     = 3'd0,
		REG_TURN     = 3'd1,
		REG_SPIN     = 3'd2,
		REG_DEBOUNCE = 3'd3,
		REG_TIMEOUT  = 3'd4,
		REG_INV_L    = 3'd5,
		REG_INV_R    = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIDE_UNKNOWN = 2'd0,
		SIDE_LEFT    = 2'd1,
		SIDE_RIGHT   = 2'd2
	} side_t;

	typedef enum logic [2:0] {
		MODE_BOTH    = 3'd0,
		MODE_LEFT    = 3'd1,
		MODE_RIGHT   = 3'd2,
		MODE_RECOVER = 3'd3,
		MODE_SPIN    = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0]  base;
		logic [7:0]  turn;
		logic [7:0]  spin;
		logic [7:0]  debounce;
		logic [15:0] timeout;
		logic        inv_l;
		logic        inv_r;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  left_run;
		logic [7:0]  right_run;
		side_t       last_side;
		logic [31:0] last_seen;
		logic        spin_phase;
	} track_t;

	typedef struct packed {
		logic signed [8:0] left_speed;
		logic signed [8:0] right_speed;
		mode_t             mode;
	} cmd_t;

	localparam logic [7:0]  RUN_MAX    = 8'd255;
	// x/3 as (x*683)>>11, exact for 0 <= x < 1024
	localparam logic [9:0]  DIV3_MUL   = 10'd683;
	localparam int          DIV3_SHIFT = 11;

	localparam cfg_t CFG_RESET = '{
		base:     8'd80,
		turn:     8'd70,
		spin:     8'd60,
		debounce: 8'd1,
		timeout:  16'd400,
		inv_l:    1'b0,
		inv_r:    1'b0
	};

endpackage

/* rtl/core/tslf_steer.sv */
module tslf_steer (
	input  tslf_pkg::cfg_t   cfg,
	input  tslf_pkg::track_t track,
	input  logic             left_raw,
	input  logic             right_raw,
	input  logic [31:0]      now_ms,
	output tslf_pkg::track_t track_next,
	output tslf_pkg::cmd_t   cmd
);
	import tslf_pkg::*;

	logic [7:0]         lrun, rrun;
	logic               ld, rd;
	logic signed [8:0]  base_s, spin_s, inner_s;
	logic [10:0]        x3;
	logic               x_neg;
	logic [9:0]         x_mag;
	logic [19:0]        prod;
	logic signed [8:0]  soft_s;
	logic [31:0]        elapsed;
	logic               recent;
	logic signed [8:0]  lv, rv;

	always_comb begin
		lrun = left_raw ? ((track.left_run == RUN_MAX) ? RUN_MAX : track.left_run + 8'd1) : 8'd0;
		rrun = right_raw ? ((track.right_run == RUN_MAX) ? RUN_MAX : track.right_run + 8'd1)
			: 8'd0;
		ld = lrun >= cfg.debounce;
		rd = rrun >= cfg.debounce;

		base_s  = signed'({1'b0, cfg.base});
		spin_s  = signed'({1'b0, cfg.spin});
		inner_s = base_s - signed'({1'b0, cfg.turn});

		// soft = (3*base - 2*turn)/3, truncated toward zero
		x3     = {2'b00, cfg.base, 1'b0} + {3'b000, cfg.base} - {2'b00, cfg.turn, 1'b0};
		x_neg  = x3[10];
		x_mag  = x_neg ? 10'(-x3) : x3[9:0];
		prod   = x_mag * DIV3_MUL;
		soft_s = x_neg ? -signed'(prod[19:DIV3_SHIFT]) : signed'(prod[19:DIV3_SHIFT]);

		elapsed = now_ms - track.last_seen;
		recent  = elapsed < {16'd0, cfg.timeout};

		track_next           = track;
		track_next.left_run  = lrun;
		track_next.right_run = rrun;
		lv = base_s;
		rv = base_s;

		if (ld || rd) begin
			track_next.last_seen = now_ms;
			if (ld && rd) begin
				cmd.mode = MODE_BOTH;
				track_next.last_side = SIDE_UNKNOWN;
			end else if (ld) begin
				cmd.mode = MODE_LEFT;
				lv = inner_s;
				track_next.last_side = SIDE_LEFT;
			end else begin
				cmd.mode = MODE_RIGHT;
				rv = inner_s;
				track_next.last_side = SIDE_RIGHT;
			end
		end else if (recent &&
				(track.last_side == SIDE_LEFT || track.last_side == SIDE_RIGHT)) begin
			cmd.mode = MODE_RECOVER;
			if (track.last_side == SIDE_LEFT) begin
				lv = soft_s;
			end else begin
				rv = soft_s;
			end
		end else begin
			cmd.mode = MODE_SPIN;
			lv = track.spin_phase ? -spin_s : spin_s;
			rv = track.spin_phase ? spin_s : -spin_s;
			track_next.spin_phase = ~track.spin_phase;
		end

		cmd.left_speed  = cfg.inv_l ? -lv : lv;
		cmd.right_speed = cfg.inv_r ? -rv : rv;
	end

endmodule

/* rtl/core/two_sensor_line_follow_steering_core.sv */
// An accepted word waits in the input register until the output register, which drives
// m_tdata, is empty or m_tready is high. Throughput: one word per cycle unless m_tready stalls;
// the sensor tracking state is updated in a single pass between the input and output registers.
// Reset (arst_n low, asynchronous): configuration returns to defaults, run counters,
// last side, last-seen time and spin phase clear, both stages empty.
`include "assert_macros.svh"

module two_sensor_line_follow_steering_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // left_raw, right_raw, now_ms[31:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // left_speed[8:0], right_speed[8:0], drive_mode[2:0], pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tslf_pkg::*;

	cfg_t        cfg_q;
	track_t      track_q, track_next;
	cmd_t        cmd_c, cmd_s2;
	logic        valid_s1, valid_s2;
	logic        left_s1, right_s1;
	logic [31:0] now_s1;
	logic        s1_move;

	assign s1_move  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:     cfg_q.base     <= cfg_data[7:0];
				REG_TURN:     cfg_q.turn     <= cfg_data[7:0];
				REG_SPIN:     cfg_q.spin     <= cfg_data[7:0];
				REG_DEBOUNCE: cfg_q.debounce <= cfg_data[7:0];
				REG_TIMEOUT:  cfg_q.timeout  <= cfg_data;
				REG_INV_L:    cfg_q.inv_l    <= cfg_data[0];
				REG_INV_R:    cfg_q.inv_r    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			left_s1  <= s_tdata[0];
			right_s1 <= s_tdata[1];
			now_s1   <= s_tdata[33:2];
		end
	end

	tslf_steer u_steer (
		.cfg        (cfg_q),
		.track      (track_q),
		.left_raw   (left_s1),
		.right_raw  (right_s1),
		.now_ms     (now_s1),
		.track_next (track_next),
		.cmd        (cmd_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '{left_run: 8'd0, right_run: 8'd0, last_side: SIDE_UNKNOWN,
				last_seen: 32'd0, spin_phase: 1'b0};
		end else if (s1_move) begin
			track_q <= track_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cmd_s2 <= cmd_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, cmd_s2.mode, cmd_s2.right_speed, cmd_s2.left_speed};

	`TSLF_ASSERT_NXT(a_move_fills_out, s1_move, valid_s2)
	`TSLF_ASSERT_NXT(a_spin_toggles, s1_move && cmd_c.mode == MODE_SPIN, track_q.spin_phase != $past(track_q.spin_phase))
	`TSLF_ASSERT_NXT(a_phase_holds, !(s1_move && cmd_c.mode == MODE_SPIN), $stable(track_q.spin_phase))

endmodule
